// File: sv/pitg_pkg.sv
package pitg_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned ReloadWidth = 17;
  localparam int unsigned CountWidth  = 32;

  localparam logic [ReloadWidth-1:0] FULL_PERIOD  = 17'h10000;
  localparam logic [ReloadWidth-1:0] RELOAD_RESET = 17'd59659;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_POLL  = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [SampleWidth-1:0] counter_sample;
  } in_word_t;

  typedef struct packed {
    logic                  tick;
    logic [CountWidth-1:0] tick_total;
  } out_word_t;

  typedef struct packed {
    logic [SampleWidth-1:0] last_sample;
    logic [CountWidth-1:0]  residue_acc;
    logic [CountWidth-1:0]  tick_cnt;
    logic                   armed;
  } state_t;

endpackage

// File: sv/pitg_if.sv
interface pitg_in_if;
  logic               valid;
  logic               ready;
  pitg_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pitg_out_if;
  logic                valid;
  logic                ready;
  pitg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pitg_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] reload_count;

  modport source (output valid, output reload_count, input ready);
  modport sink (input valid, input reload_count, output ready);
endinterface

// File: sv/pitg_step.sv
module pitg_step
  import pitg_pkg::*;
(
  input  state_t                 state_cur,
  input  in_word_t               item,
  input  logic [ReloadWidth-1:0] reload_count,
  output state_t                 state_nxt,
  output out_word_t              result
);

  logic [ReloadWidth-1:0] cur;
  logic [ReloadWidth-1:0] prev;
  logic [ReloadWidth-1:0] rel;
  logic [ReloadWidth+1:0] wrap_diff;
  logic [CountWidth-1:0]  elapsed;
  logic [CountWidth-1:0]  sum;
  logic [CountWidth:0]    sum_minus_rel;
  logic                   reached;

  always_comb begin
    cur  = (item.counter_sample == '0) ? FULL_PERIOD : {1'b0, item.counter_sample};
    prev = (state_cur.last_sample == '0) ? FULL_PERIOD : {1'b0, state_cur.last_sample};
    if ((reload_count == '0) || (reload_count > FULL_PERIOD)) begin
      rel = FULL_PERIOD;
    end else begin
      rel = reload_count;
    end
  end

  // wrap at reload, may go negative when sample sits above reload
  always_comb begin
    wrap_diff = {2'b00, prev} + {2'b00, rel} - {2'b00, cur};
    if (prev >= cur) begin
      elapsed = {{(CountWidth-ReloadWidth){1'b0}}, prev - cur};
    end else begin
      elapsed = {{(CountWidth-ReloadWidth-2){wrap_diff[ReloadWidth+1]}}, wrap_diff};
    end
    sum           = state_cur.residue_acc + elapsed;
    sum_minus_rel = {1'b0, sum} - {{(CountWidth-ReloadWidth+1){1'b0}}, rel};
    reached       = !sum_minus_rel[CountWidth];
  end

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    unique case (item.mode)
      MODE_START: begin
        state_nxt.last_sample = item.counter_sample;
        state_nxt.residue_acc = '0;
        state_nxt.tick_cnt    = '0;
        state_nxt.armed       = 1'b1;
        result.tick           = 1'b0;
        result.tick_total     = '0;
      end
      MODE_POLL: begin
        if (state_cur.armed) begin
          state_nxt.last_sample = item.counter_sample;
          if (reached) begin
            state_nxt.residue_acc = sum_minus_rel[CountWidth-1:0];
            state_nxt.tick_cnt    = state_cur.tick_cnt + 32'd1;
          end else begin
            state_nxt.residue_acc = sum;
          end
          result.tick       = reached;
          result.tick_total = state_nxt.tick_cnt;
        end else begin
          result.tick       = 1'b0;
          result.tick_total = state_cur.tick_cnt;
        end
      end
      default: begin
        state_nxt = state_cur;
        result    = '0;
      end
    endcase
  end

endmodule

// File: sv/polled_interval_tick_generator_top.sv
// polled interval tick generator
// in_ch carries words of mode and counter_sample: a start word (mode 0) takes
// the sample as baseline, clears the residue and the tick count and arms the
// block; a poll word (mode 1) adds the counts elapsed since the last sample,
// allowing one wrap at the reload value, and ticks once the residue reaches
// the reload value.
// out_ch returns exactly one word per input word: tick and tick_total.
// cfg_ch writes reload_count (0 or above 65536 act as 65536); write it only
// while no word is in flight. cfg_ch.ready is always high.
// input acceptance to out_ch.valid passes one input register and one result
// register, with the update logic between them.
// throughput: one word per cycle while out_ch.ready holds; the residue update is combinational.
// reset: reload_count returns to 59659, the block is unarmed, both stages empty.
// a poll before the first start returns tick 0 and tick_total 0.
// stall: a held result keeps its value; one more word waits in the input
// register, then in_ch.ready drops until out_ch.ready returns.
module polled_interval_tick_generator_top
  import pitg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  pitg_in_if.sink    in_ch,
  pitg_out_if.source out_ch,
  pitg_cfg_if.sink   cfg_ch
);

  logic                   s0_valid_r;
  in_word_t               s0_word_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;
  state_t                 state_r;
  state_t                 state_nxt;
  out_word_t              out_word_nxt;
  logic [ReloadWidth-1:0] reload_r;
  logic                   s0_adv;
  logic                   in_acc;

  assign s0_adv = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s0_valid_r || s0_adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  pitg_step u_step (
    .state_cur    (state_r),
    .item         (s0_word_r),
    .reload_count (reload_r),
    .state_nxt    (state_nxt),
    .result       (out_word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= RELOAD_RESET;
    end else if (cfg_ch.valid) begin
      reload_r <= cfg_ch.reload_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_acc) begin
      s0_valid_r <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_word_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s0_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  a_reset_unarmed: assert property (@(posedge clk)
    !rst_n |=> !state_r.armed && !s0_valid_r && !out_valid_r)
    else $error("state not cleared by reset");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s0_adv && (s0_word_r.mode == MODE_START) |=>
      state_r.armed && (state_r.residue_acc == '0) && (state_r.tick_cnt == '0))
    else $error("start word did not clear and arm");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s0_adv && out_word_nxt.tick |=>
      (state_r.tick_cnt == $past(state_r.tick_cnt) + 32'd1) &&
      (out_word_r.tick_total == state_r.tick_cnt))
    else $error("tick not reflected in count");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !s0_adv |=> $stable(state_r))
    else $error("state changed without a word");
`endif

endmodule
